// File: src/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared widths, request codes and payload types of the mean squared
// displacement accumulator.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int COORD_W = 24;           // signed q12.12 coordinate
  localparam int MAG_W   = COORD_W + 1;  // magnitude of a coordinate difference
  localparam int SQ_W    = 2 * MAG_W - 1; // one square, at most 2^48
  localparam int D2_W    = SQ_W + 1;     // sum of three squares, below 2^50
  localparam int SUM_W   = 63;           // saturating lag sum, q39.24
  localparam int CNT_W   = 32;           // saturating pair count
  localparam int LAG_W   = 6;

  // request action codes
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      first_of_bead;
    logic [LAG_W-1:0]          lag;
  } msd_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] lag_sum;
    logic [CNT_W-1:0] lag_count;
    logic             overflow;
  } msd_rsp_t;

  // control from the sequencer to the lag accumulator store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } acc_cmd_t;

endpackage

// File: src/mean_squared_displacement_accumulator.sv
// ----------------------------------------------------------------------------
// A read request gives its result strobe in the cycle after it.
// A push with n frames already stored stays busy for one round per stored frame
// (one read, three passes of the shared square unit, one sum and one write-back).
// A clear, a dropped sample or a first frame leaves the block idle.
// Synchronous reset empties the frame store and zeroes all sums and counts.
// Results cannot be stalled: each strobe lasts one cycle.
// ----------------------------------------------------------------------------
// mean_squared_displacement_accumulator
// Accumulates squared displacements per frame lag over all time origins,
// using one shared square-of-difference unit under a small sequencer.
// ----------------------------------------------------------------------------
module mean_squared_displacement_accumulator #(
  parameter int MAX_FRAMES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  msd_pkg::msd_req_t req,
  output logic              done,
  output msd_pkg::msd_rsp_t rsp
);

  localparam int AW  = $clog2(MAX_FRAMES);
  localparam int FCW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_X    = 8'b0000_0100,
    S_Y    = 8'b0000_1000,
    S_Z    = 8'b0001_0000,
    S_SUM  = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_RSP  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic signed [msd_pkg::COORD_W-1:0] frame_x [MAX_FRAMES];
  logic signed [msd_pkg::COORD_W-1:0] frame_y [MAX_FRAMES];
  logic signed [msd_pkg::COORD_W-1:0] frame_z [MAX_FRAMES];
  logic signed [msd_pkg::COORD_W-1:0] fq_x, fq_y, fq_z;
  logic signed [msd_pkg::COORD_W-1:0] px, py, pz;
  logic signed [msd_pkg::COORD_W-1:0] op_a, op_b;

  logic [FCW-1:0]            frame_count;
  logic [FCW-1:0]            n_eff;
  logic                      dropped_flag;
  logic [AW-1:0]             j;
  logic [AW-1:0]             lg;
  logic                      in_range;
  logic                      accept;
  logic                      store_full;

  logic [msd_pkg::SQ_W-1:0]  sq;
  logic [msd_pkg::D2_W-1:0]  d2;
  logic [msd_pkg::SUM_W:0]   sum_wide;
  logic [msd_pkg::SUM_W-1:0] new_sum;
  logic [msd_pkg::CNT_W-1:0] new_cnt;
  logic [msd_pkg::SUM_W-1:0] acc_sum;
  logic [msd_pkg::CNT_W-1:0] acc_cnt;
  logic [AW-1:0]             acc_rd_addr;
  msd_pkg::acc_cmd_t         acc_cmd;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign n_eff      = req.first_of_bead ? '0 : frame_count;
  assign store_full = (n_eff >= FCW'(MAX_FRAMES));

  // shared square unit, operands chosen by the sequencer phase
  always_comb begin
    case (state)
      S_Y: begin
        op_a = py;
        op_b = fq_y;
      end
      S_Z: begin
        op_a = pz;
        op_b = fq_z;
      end
      default: begin
        op_a = px;
        op_b = fq_x;
      end
    endcase
  end

  msd_sqdiff u_sqdiff (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .sq  (sq)
  );

  // saturating update of one lag entry
  assign sum_wide = {1'b0, acc_sum} + (msd_pkg::SUM_W + 1)'(d2);
  assign new_sum  = sum_wide[msd_pkg::SUM_W] ? '1 : sum_wide[msd_pkg::SUM_W-1:0];
  assign new_cnt  = (&acc_cnt) ? acc_cnt : acc_cnt + 1'b1;

  // lag store control
  assign acc_rd_addr   = (state == S_RD) ? lg : req.lag[AW-1:0];
  assign acc_cmd.rd_en = (state == S_RD) || (accept && req.action == msd_pkg::ACT_READ);
  assign acc_cmd.wr_en = (state == S_WR);
  assign acc_cmd.clear = accept && req.action == msd_pkg::ACT_CLEAR;

  msd_acc_store #(
    .DEPTH (MAX_FRAMES)
  ) u_acc_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (acc_cmd),
    .rd_addr (acc_rd_addr),
    .wr_addr (lg),
    .wr_sum  (new_sum),
    .wr_cnt  (new_cnt),
    .rd_sum  (acc_sum),
    .rd_cnt  (acc_cnt)
  );

  // frame store: written on push request, read once per pair
  always_ff @(posedge clk) begin
    if (accept && req.action == msd_pkg::ACT_PUSH && !store_full) begin
      frame_x[n_eff[AW-1:0]] <= req.pos_x;
      frame_y[n_eff[AW-1:0]] <= req.pos_y;
      frame_z[n_eff[AW-1:0]] <= req.pos_z;
    end
    if (state == S_RD) begin
      fq_x <= frame_x[j];
      fq_y <= frame_y[j];
      fq_z <= frame_z[j];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.action)
            msd_pkg::ACT_PUSH: begin
              if (!store_full && n_eff != '0) begin
                state_next = S_RD;
              end
            end
            msd_pkg::ACT_READ: state_next = S_RSP;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_RD:  state_next = S_X;
      S_X:   state_next = S_Y;
      S_Y:   state_next = S_Z;
      S_Z:   state_next = S_SUM;
      S_SUM: state_next = S_WR;
      S_WR:  state_next = (lg == AW'(1)) ? S_IDLE : S_RD;
      S_RSP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_count  <= '0;
      dropped_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (req.action)
          msd_pkg::ACT_PUSH: begin
            if (store_full) begin
              frame_count  <= n_eff;
              dropped_flag <= 1'b1;
            end else begin
              frame_count <= n_eff + 1'b1;
            end
          end
          msd_pkg::ACT_CLEAR: begin
            frame_count  <= '0;
            dropped_flag <= 1'b0;
          end
          default: begin
            frame_count <= frame_count;
          end
        endcase
      end
    end
  end

  // per-request datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px       <= req.pos_x;
      py       <= req.pos_y;
      pz       <= req.pos_z;
      j        <= '0;
      lg       <= n_eff[AW-1:0];
      in_range <= ({1'b0, req.lag} < (msd_pkg::LAG_W + 1)'(MAX_FRAMES));
    end else if (state == S_WR) begin
      j  <= j + 1'b1;
      lg <= lg - 1'b1;
    end
    // squared distance built up over three passes of the shared unit
    case (state)
      S_Y:     d2 <= msd_pkg::D2_W'(sq);
      S_Z:     d2 <= d2 + msd_pkg::D2_W'(sq);
      S_SUM:   d2 <= d2 + msd_pkg::D2_W'(sq);
      default: d2 <= d2;
    endcase
  end

  // result
  assign done          = (state == S_RSP);
  assign rsp.lag_sum   = in_range ? acc_sum : '0;
  assign rsp.lag_count = in_range ? acc_cnt : '0;
  assign rsp.overflow  = dropped_flag;

  // checks
  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && req.action == msd_pkg::ACT_READ))
    else $error("result strobe without a read request");

  a_count_stable_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(frame_count))
    else $error("frame count changed while busy");

  a_lag_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (lg != '0))
    else $error("write-back at lag zero");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= FCW'(MAX_FRAMES))
    else $error("frame count beyond capacity");

endmodule

// File: src/msd_sqdiff.sv
// ----------------------------------------------------------------------------
// msd_sqdiff
// Shared square-of-difference unit: subtracts two coordinates, takes the
// magnitude and squares it, with a registered result.
// ----------------------------------------------------------------------------
module msd_sqdiff (
  input  logic                               clk,
  input  logic signed [msd_pkg::COORD_W-1:0] a,
  input  logic signed [msd_pkg::COORD_W-1:0] b,
  output logic        [msd_pkg::SQ_W-1:0]    sq
);

  logic signed [msd_pkg::MAG_W-1:0]   diff;
  logic        [msd_pkg::MAG_W-1:0]   mag;
  logic        [2*msd_pkg::MAG_W-1:0] prod;

  // sign-extended difference and its magnitude
  assign diff = {a[msd_pkg::COORD_W-1], a} - {b[msd_pkg::COORD_W-1], b};
  assign mag  = diff[msd_pkg::MAG_W-1] ? msd_pkg::MAG_W'(-diff) : msd_pkg::MAG_W'(diff);
  assign prod = mag * mag;

  // registered square
  always_ff @(posedge clk) begin
    sq <= prod[msd_pkg::SQ_W-1:0];
  end

endmodule

// File: src/msd_acc_store.sv
// ----------------------------------------------------------------------------
// msd_acc_store
// Per-lag sum and count memory with one valid bit per entry, so that a
// clear empties all entries together without walking the memory.
// ----------------------------------------------------------------------------
module msd_acc_store #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  msd_pkg::acc_cmd_t                 cmd,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [msd_pkg::SUM_W-1:0]         wr_sum,
  input  logic [msd_pkg::CNT_W-1:0]         wr_cnt,
  output logic [msd_pkg::SUM_W-1:0]         rd_sum,
  output logic [msd_pkg::CNT_W-1:0]         rd_cnt
);

  logic [msd_pkg::SUM_W-1:0] sum_mem [DEPTH];
  logic [msd_pkg::CNT_W-1:0] cnt_mem [DEPTH];
  logic [DEPTH-1:0]          valid;
  logic [msd_pkg::SUM_W-1:0] sum_q;
  logic [msd_pkg::CNT_W-1:0] cnt_q;
  logic                      valid_q;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      sum_mem[wr_addr] <= wr_sum;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (cmd.rd_en) begin
      sum_q <= sum_mem[rd_addr];
      cnt_q <= cnt_mem[rd_addr];
    end
  end

  // valid bits, cleared by reset and by a clear request
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        valid_q <= valid[rd_addr];
      end
      if (cmd.clear) begin
        valid <= '0;
      end else if (cmd.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  // an entry never written since clear reads as zero
  assign rd_sum = valid_q ? sum_q : '0;
  assign rd_cnt = valid_q ? cnt_q : '0;

endmodule
